// ----- hw/rtl/simon_pkg.sv -----
// Shared types, constants and round functions for the Simon 128/256 cipher.
// No dependencies; every other file in hw/rtl except simon_ram imports this package.
package simon_pkg;

    localparam int ROUND_COUNT = 72;
    localparam int RND_W       = $clog2(ROUND_COUNT);
    localparam int WORD_W      = 64;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_IDX_W   = $clog2(KEY_WORDS);
    localparam int ADDR_W      = KEY_IDX_W + 3;   // 8-byte register stride

    localparam logic [WORD_W-1:0] KEY_CONST = 64'hffff_ffff_ffff_fffc;
    localparam logic [WORD_W-1:0] Z_SEQ     = 64'hfdc9_4c3a_046d_678b;

    // Item op codes
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [RND_W-1:0]     rnd_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;

    localparam rnd_t LAST_RND = RND_W'(ROUND_COUNT - 1);

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;   // capture block halves
        logic load_keys;   // capture key words for expansion
        logic key_step;    // one key-schedule step, write k0 to store
        logic round_step;  // one Feistel round with the store's read data
        logic out_load;    // move working halves to output register
        logic dec;         // current item decrypts
        rnd_t waddr;
        rnd_t raddr;
    } cmd_t;

    // f(x) = (x <<< 1 & x <<< 8) ^ x <<< 2
    function automatic word_t round_f(input word_t v);
        round_f = ({v[62:0], v[63]} & {v[55:0], v[63:56]}) ^ {v[61:0], v[63:62]};
    endfunction

    // z-sequence bit: 64 stored bits, then 0, 1, and 0 for the remaining rounds
    function automatic logic seq_bit(input rnd_t s);
        if (s < RND_W'(64))
            seq_bit = Z_SEQ[s[5:0]];
        else
            seq_bit = (s == RND_W'(65));
    endfunction

    // New newest key word from oldest (k0), second oldest (k1), newest (k3)
    function automatic word_t key_next(input word_t k0, input word_t k1,
                                       input word_t k3, input rnd_t s);
        key_next = k0 ^ KEY_CONST ^ {{(WORD_W-1){1'b0}}, seq_bit(s)}
                 ^ {k3[2:0], k3[63:3]} ^ {k3[3:0], k3[63:4]}
                 ^ k1 ^ {k1[0], k1[63:1]};
    endfunction

endpackage

// ----- hw/rtl/simon_if.sv -----
// Valid/ready channel interfaces for input blocks and result blocks.
// Depends on simon_pkg.
interface simon_req_if;
    import simon_pkg::*;
    logic  valid;
    logic  ready;
    logic  op;
    word_t block_lo;
    word_t block_hi;
    modport source (output valid, output op, output block_lo, output block_hi,
                    input ready);
    modport sink   (input valid, input op, input block_lo, input block_hi,
                    output ready);
endinterface

interface simon_rsp_if;
    import simon_pkg::*;
    logic  valid;
    logic  ready;
    word_t result_lo;
    word_t result_hi;
    modport source (output valid, output result_lo, output result_hi, input ready);
    modport sink   (input valid, input result_lo, input result_hi, output ready);
endinterface

// ----- hw/rtl/simon_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module simon_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 72,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- hw/rtl/simon_dp.sv -----
// Datapath: key-schedule shift registers, round-key store, round unit and
// output register. Depends on simon_pkg and simon_ram.
module simon_dp (
    input  logic            clk,
    input  simon_pkg::cmd_t cmd,
    input  logic            op,
    input  simon_pkg::word_t block_lo,
    input  simon_pkg::word_t block_hi,
    input  simon_pkg::word_t key_word_0,
    input  simon_pkg::word_t key_word_1,
    input  simon_pkg::word_t key_word_2,
    input  simon_pkg::word_t key_word_3,
    output simon_pkg::word_t result_lo,
    output simon_pkg::word_t result_hi
);
    import simon_pkg::*;

    word_t k0_reg, k1_reg, k2_reg, k3_reg;
    word_t a_reg, b_reg;          // a: half fed to f(), b: other half
    word_t res_lo_reg, res_hi_reg;
    word_t rk;

    simon_ram #(.WIDTH(WORD_W), .DEPTH(ROUND_COUNT)) u_store (
        .clk   (clk),
        .we    (cmd.key_step),
        .waddr (cmd.waddr),
        .wdata (k0_reg),
        .raddr (cmd.raddr),
        .rdata (rk)
    );

    // Key schedule: k0 oldest, k3 newest
    always_ff @(posedge clk)
    begin
        if (cmd.load_keys)
        begin
            k0_reg <= key_word_0;
            k1_reg <= key_word_1;
            k2_reg <= key_word_2;
            k3_reg <= key_word_3;
        end
        else if (cmd.key_step)
        begin
            k0_reg <= k1_reg;
            k1_reg <= k2_reg;
            k2_reg <= k3_reg;
            k3_reg <= key_next(k0_reg, k1_reg, k3_reg, cmd.waddr);
        end
    end

    // Decrypt runs the same round with the halves swapped
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            a_reg <= (op == OP_DEC) ? block_lo : block_hi;
            b_reg <= (op == OP_DEC) ? block_hi : block_lo;
        end
        else if (cmd.round_step)
        begin
            a_reg <= b_reg ^ round_f(a_reg) ^ rk;
            b_reg <= a_reg;
        end
        if (cmd.out_load)
        begin
            res_hi_reg <= cmd.dec ? b_reg : a_reg;
            res_lo_reg <= cmd.dec ? a_reg : b_reg;
        end
    end

    assign result_lo = res_lo_reg;
    assign result_hi = res_hi_reg;
endmodule

// ----- hw/rtl/simon_ctrl.sv -----
// Controller: sequences key expansion, rounds and result hand-off.
// Depends on simon_pkg.
module simon_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr,
    input  logic            req_valid,
    input  logic            req_op,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output simon_pkg::cmd_t cmd
);
    import simon_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_FETCH,
        S_RUN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    rnd_t   cnt_reg, cnt_next;
    logic   dec_reg, dec_next;
    logic   keys_ready_reg, keys_ready_next;
    logic   out_valid_reg, out_valid_next;

    function automatic rnd_t key_idx(input logic dec, input rnd_t r);
        key_idx = dec ? (LAST_RND - r) : r;
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        dec_next        = dec_reg;
        keys_ready_next = keys_ready_reg;
        out_valid_next  = out_valid_reg;
        cmd             = '0;
        cmd.dec         = dec_reg;
        cmd.waddr       = cnt_reg;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.load_keys = !keys_ready_reg;
                    dec_next      = (req_op == OP_DEC);
                    cnt_next      = '0;
                    state_next    = keys_ready_reg ? S_FETCH : S_EXPAND;
                end
            end
            S_EXPAND:
            begin
                cmd.key_step = 1'b1;
                if (cnt_reg == LAST_RND)
                begin
                    keys_ready_next = 1'b1;
                    cnt_next        = '0;
                    state_next      = S_FETCH;
                end
                else
                begin
                    cnt_next = cnt_reg + RND_W'(1);
                end
            end
            S_FETCH:
            begin
                cmd.raddr  = key_idx(dec_reg, '0);
                cnt_next   = '0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.round_step = 1'b1;
                if (cnt_reg == LAST_RND)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.raddr = key_idx(dec_reg, cnt_reg + RND_W'(1));
                    cnt_next  = cnt_reg + RND_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // key writes must arrive only while idle; the controller does not enforce this
        if (cfg_wr)
        begin
            keys_ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            dec_reg        <= 1'b0;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            dec_reg        <= dec_next;
            keys_ready_reg <= keys_ready_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    // rounds only run on an expanded key
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_step |-> keys_ready_reg)
        else $error("round started without round keys");

    // store writes stay within the schedule length
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.key_step |-> (cnt_reg <= LAST_RND))
        else $error("key step beyond last round key");

    // expansion completes straight into the first key fetch
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXPAND && cnt_reg == LAST_RND) |=>
        (state_reg == S_FETCH && keys_ready_reg))
        else $error("expansion did not hand over to the rounds");

    // a result is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp_ready))
        else $error("pending result overwritten");
endmodule

// ----- hw/rtl/simon128_256_block_cipher.sv -----
// Simon 128/256 block cipher top level: APB key registers, controller, datapath.
// Depends on simon_pkg, simon_if, simon_ctrl, simon_dp (and simon_ram).
//
// The 256-bit key is written as four 64-bit words at byte addresses 0, 8, 16
// and 24 (word 0 least significant); reads return the written words, reset
// is zero. Any key write marks the round keys stale. The first item after
// reset or a key change first runs the key schedule, one round key written
// per cycle into a 72 x 64 RAM (no clearing pass; the RAM is always filled
// before it is read). Each item then passes through a fetch state that primes
// the RAM's registered read port, 72 rounds at one round per cycle (one round
// key read per cycle), and a done state that moves the result into the output
// register. Items are accepted only in idle, so a new item is not taken until
// the previous one has left the done state; a result that is not taken
// holds the next one in its done state. op = 0 encrypts, op = 1 decrypts.
// One item is in flight at a time; a new item is accepted while the previous
// result still waits in the output register.
module simon128_256_block_cipher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  simon_pkg::addr_t    paddr,
    input  simon_pkg::word_t    pwdata,
    output simon_pkg::word_t    prdata,
    output logic                pready,
    simon_req_if.sink           req,
    simon_rsp_if.source         rsp
);
    import simon_pkg::*;

    word_t    key_reg [KEY_WORDS];
    key_idx_t key_sel;
    logic     cfg_wr;
    cmd_t     cmd;

    // register index from the 8-byte stride; low byte-offset bits ignored
    assign key_sel = paddr[ADDR_W-1:3];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = key_reg[key_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            key_reg[key_sel] <= pwdata;
        end
    end

    simon_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    simon_dp u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .op         (req.op),
        .block_lo   (req.block_lo),
        .block_hi   (req.block_hi),
        .key_word_0 (key_reg[0]),
        .key_word_1 (key_reg[1]),
        .key_word_2 (key_reg[2]),
        .key_word_3 (key_reg[3]),
        .result_lo  (rsp.result_lo),
        .result_hi  (rsp.result_hi)
    );
endmodule
